// ----- hdl/fidx_pkg.sv -----
// ----------------------------------------------------------------------------
// fidx_pkg
// Shared widths and codes for the flat index radix converter.
// ----------------------------------------------------------------------------
package fidx_pkg;

	localparam int VALUE_W   = 32;  // flat position / digit on the channels
	localparam int RADIX_W   = 16;
	localparam int COUNT_W   = 4;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W     = 16;  // widest register

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_RADIX       = 1'd0;
	localparam cfg_idx_t REG_DIGIT_COUNT = 1'd1;

	localparam logic CMD_SPLIT = 1'b0;
	localparam logic CMD_JOIN  = 1'b1;

endpackage

// ----- hdl/fidx_if.sv -----
// ----------------------------------------------------------------------------
// fidx_if
// Valid/ready channels of the flat index radix converter.
// ----------------------------------------------------------------------------
interface fidx_req_if;
	logic                         valid;
	logic                         ready;
	logic                         cmd;
	logic [fidx_pkg::VALUE_W-1:0] value_in;

	modport source (output valid, output cmd, output value_in, input ready);
	modport sink (input valid, input cmd, input value_in, output ready);
endinterface

interface fidx_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [fidx_pkg::VALUE_W-1:0] value_out;
	logic                         last;

	modport source (output valid, output value_out, output last, input ready);
	modport sink (input valid, input value_out, input last, output ready);
endinterface

// ----- hdl/flat_index_radix_converter.sv -----
// ----------------------------------------------------------------------------
// flat_index_radix_converter
// Split a flat position into base-radix digits, or join digits back into one.
// ----------------------------------------------------------------------------
// usage
//  req carries cmd and value_in. cmd split: value_in is a position and the
//  block returns digit_count digits (taken as 1..MAX_RANK) on rsp, least
//  significant first, last set on the final one. cmd join: value_in is one
//  digit; the digit_count-th join transaction returns the assembled position
//  with last set, others return nothing. radix and digit_count are written
//  through cfg_we/cfg_index/cfg_wdata while the block is idle.
//  split: each digit is divided out of the POS_WIDTH-bit position by the
//  4-bit-per-cycle divider, then the output register is loaded. a join
//  accepts the digit and runs a shift-add multiplier over the digit, which
//  stops early once the remaining multiplier bits are zero, and then over
//  the radix; on the completing digit it loads the output register.
//  req.ready is high only between items. a stalled rsp holds the sequencer
//  in its output state; nothing is dropped.
//  reset: radix 2, digit_count 1, join state cleared, output empty.
// ----------------------------------------------------------------------------
module flat_index_radix_converter #(
	parameter int MAX_RANK  = 8,
	parameter int POS_WIDTH = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  fidx_pkg::cfg_idx_t           cfg_index,
	input  logic [fidx_pkg::CFG_W-1:0]   cfg_wdata,
	fidx_req_if.sink                     req,
	fidx_rsp_if.source                   rsp
);

	localparam int PW        = POS_WIDTH;
	localparam int RW        = fidx_pkg::RADIX_W;
	localparam int VW        = fidx_pkg::VALUE_W;
	localparam int BPS       = 4;                      // quotient bits per cycle
	localparam int DIV_STEPS = (PW + BPS - 1) / BPS;
	localparam int DIV_W     = DIV_STEPS * BPS;
	localparam int STEP_W    = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
	localparam int CNT_W     = 5;
	localparam int IDX_W     = fidx_pkg::COUNT_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV,
		S_EMIT,
		S_MSUM,
		S_MSCALE,
		S_JOIN_OUT
	} state_t;

	state_t               state_q;
	logic [RW-1:0]        radix_q;
	logic [IDX_W-1:0]     digit_count_q;
	logic [PW-1:0]        join_sum_q;
	logic [PW-1:0]        join_scale_q;
	logic [IDX_W-1:0]     join_idx_q;
	logic [DIV_W-1:0]     rem_q;
	logic [RW-1:0]        part_q;
	logic [STEP_W-1:0]    step_q;
	logic [IDX_W-1:0]     digit_idx_q;
	logic [CNT_W-1:0]     count_q;
	logic [PW-1:0]        mcand_q;
	logic [VW-1:0]        mplier_q;
	logic [PW-1:0]        acc_q;
	logic                 out_valid_q;
	logic [VW-1:0]        out_value_q;
	logic                 out_last_q;

	logic [CNT_W-1:0]     eff_count;
	logic [DIV_W-1:0]     rem_next;
	logic [RW-1:0]        part_next;
	logic                 slot_free;
	logic                 out_load;
	logic                 split_last;
	logic [IDX_W-1:0]     join_idx_inc;
	logic                 join_done;
	logic [PW-1:0]        acc_add;

	always_comb begin
		if (digit_count_q == '0) begin
			eff_count = CNT_W'(1);
		end else if (CNT_W'(digit_count_q) > CNT_W'(MAX_RANK)) begin
			eff_count = CNT_W'(MAX_RANK);
		end else begin
			eff_count = CNT_W'(digit_count_q);
		end
	end

	// restoring division, four quotient bits a cycle
	always_comb begin
		logic [DIV_W-1:0] r;
		logic [RW-1:0]    p;
		logic [RW:0]      trial;
		r = rem_q;
		p = part_q;
		for (int k = 0; k < BPS; k++) begin
			trial = {p, r[DIV_W-1]};
			r     = {r[DIV_W-2:0], 1'b0};
			if (trial >= {1'b0, radix_q}) begin
				trial = trial - {1'b0, radix_q};
				r[0]  = 1'b1;
			end
			p = trial[RW-1:0];
		end
		rem_next  = r;
		part_next = p;
	end

	assign slot_free    = !out_valid_q || rsp.ready;
	assign out_load     = slot_free && (state_q == S_EMIT || state_q == S_JOIN_OUT);
	assign split_last   = (CNT_W'(digit_idx_q) + CNT_W'(1)) == count_q;
	assign join_idx_inc = join_idx_q + IDX_W'(1);
	assign join_done    = (CNT_W'(join_idx_inc) >= count_q) || (join_idx_inc == '0);
	assign acc_add      = acc_q + mcand_q;

	assign req.ready     = (state_q == S_IDLE);
	assign rsp.valid     = out_valid_q;
	assign rsp.value_out = out_value_q;
	assign rsp.last      = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			radix_q       <= RW'(2);
			digit_count_q <= IDX_W'(1);
			join_sum_q    <= '0;
			join_scale_q  <= PW'(1);
			join_idx_q    <= '0;
			out_valid_q   <= 1'b0;
			step_q        <= '0;
			digit_idx_q   <= '0;
			count_q       <= CNT_W'(1);
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					fidx_pkg::REG_RADIX:       radix_q       <= cfg_wdata[RW-1:0];
					fidx_pkg::REG_DIGIT_COUNT: digit_count_q <= cfg_wdata[IDX_W-1:0];
					default: ;
				endcase
			end

			if (rsp.ready && !out_load) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						count_q <= eff_count;
						if (req.cmd == fidx_pkg::CMD_SPLIT) begin
							rem_q       <= DIV_W'(PW'(req.value_in));
							part_q      <= '0;
							step_q      <= '0;
							digit_idx_q <= '0;
							state_q     <= (radix_q == '0) ? S_EMIT : S_DIV;
						end else begin
							mplier_q <= req.value_in;
							mcand_q  <= join_scale_q;
							acc_q    <= join_sum_q;
							state_q  <= S_MSUM;
						end
					end
				end
				S_DIV: begin
					rem_q  <= rem_next;
					part_q <= part_next;
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(DIV_STEPS - 1)) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						out_last_q  <= split_last;
						if (radix_q == '0) begin
							// divide by zero: whole remainder is the digit
							out_value_q <= VW'(rem_q);
							rem_q       <= '0;
						end else begin
							out_value_q <= VW'(part_q);
						end
						part_q      <= '0;
						step_q      <= '0;
						digit_idx_q <= digit_idx_q + IDX_W'(1);
						if (split_last) begin
							state_q <= S_IDLE;
						end else begin
							state_q <= (radix_q == '0) ? S_EMIT : S_DIV;
						end
					end
				end
				S_MSUM: begin
					if (mplier_q == '0) begin
						join_sum_q <= acc_q;
						acc_q      <= '0;
						mcand_q    <= join_scale_q;
						mplier_q   <= VW'(radix_q);
						state_q    <= S_MSCALE;
					end else begin
						if (mplier_q[0]) begin
							acc_q <= acc_add;
						end
						mcand_q  <= {mcand_q[PW-2:0], 1'b0};
						mplier_q <= {1'b0, mplier_q[VW-1:1]};
					end
				end
				S_MSCALE: begin
					if (mplier_q == '0) begin
						join_scale_q <= acc_q;
						join_idx_q   <= join_idx_inc;
						state_q      <= join_done ? S_JOIN_OUT : S_IDLE;
					end else begin
						if (mplier_q[0]) begin
							acc_q <= acc_add;
						end
						mcand_q  <= {mcand_q[PW-2:0], 1'b0};
						mplier_q <= {1'b0, mplier_q[VW-1:1]};
					end
				end
				S_JOIN_OUT: begin
					if (slot_free) begin
						out_valid_q  <= 1'b1;
						out_last_q   <= 1'b1;
						out_value_q  <= VW'(join_sum_q);
						join_sum_q   <= '0;
						join_scale_q <= PW'(1);
						join_idx_q   <= '0;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// remainder from the divider is always below the radix
	a_rem_below_radix: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && radix_q != '0) |-> (part_q < radix_q))
		else $error("split remainder not below radix");

	// a split never runs past its digit count
	a_digit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV || state_q == S_EMIT) |-> (CNT_W'(digit_idx_q) < count_q))
		else $error("split digit index past count");

	// the output register is only loaded once its previous content is taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_valid_q || rsp.ready))
		else $error("output register overwritten");

	// a completed join leaves the join sum, scale and index reset
	a_join_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_JOIN_OUT && slot_free) |=>
			(join_sum_q == '0 && join_scale_q == PW'(1) && join_idx_q == '0
			 && state_q == S_IDLE && out_last_q))
		else $error("join state not cleared after result");

endmodule
